// ===== rtl/core/lkxc_pkg.sv =====
// Shared types and constants for the LCG keystream XOR cipher.
package lkxc_pkg;

  // Bytes per keystream word and word width
  localparam int unsigned WORD_BYTES = 4;
  localparam int unsigned WORD_W     = 8 * WORD_BYTES;
  localparam int unsigned POS_W      = $clog2(WORD_BYTES);
  localparam int unsigned PROD_W     = 2 * WORD_W;

  // Shift-subtract reduction: one dividend bit per cycle
  localparam int unsigned DIV_STEPS  = PROD_W;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DAT_W  = 32;
  localparam int unsigned SEED_W     = 31;

  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INCREMENT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED       = 2'd3;

  localparam logic [WORD_W-1:0] MULT_RST = 32'd1103515245;
  localparam logic [WORD_W-1:0] INCR_RST = 32'd12345;
  localparam logic [WORD_W-1:0] MOD_RST  = 32'h8000_0000;
  localparam logic [SEED_W-1:0] SEED_RST = 31'd1;

  // Input and result words
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
  } lkxc_in_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       last_out;
  } lkxc_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;    // accept input word, write result register
    logic mul;     // register multiplier * key
    logic add;     // add increment, load dividend, clear remainder
    logic step;    // one shift-subtract step
    logic key_ld;  // load next key word
  } lkxc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic wrap;      // word being taken uses the last key byte
    logic mod_zero;  // modulus register is zero
    logic out_free;  // result register can take a word this cycle
  } lkxc_sts_t;

endpackage

// ===== rtl/core/lkxc_ctrl.sv =====
// Controller: sequences byte handling and the next-key computation.
module lkxc_ctrl import lkxc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lkxc_sts_t sts_i,
  output lkxc_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             take;

  // Accept only when idle and the result register has room
  assign in_ready_o = (state_q == ST_IDLE) && sts_i.out_free;
  assign take       = in_ready_o && in_valid_i;

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.take = take;
        if (take && sts_i.wrap) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        cnt_d     = '0;
        state_d   = sts_i.mod_zero ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.key_ld = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/lkxc_dp.sv =====
// Datapath: config registers, key word, byte XOR, multiply and modulo unit.
module lkxc_dp import lkxc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lkxc_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lkxc_out_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  lkxc_cmd_t            cmd_i,
  output lkxc_sts_t            sts_o
);

  logic [WORD_W-1:0] mult_q, incr_q, mod_q;
  logic [SEED_W-1:0] seed_q;
  logic [WORD_W-1:0] key_q;
  logic [POS_W-1:0]  pos_q;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [PROD_W-1:0] dvd_q, dvd_d;
  logic [WORD_W-1:0] rem_q;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   rem_sub;
  logic [WORD_W-1:0] rem_d;
  logic              out_valid_q;
  lkxc_out_t         out_q;
  logic [WORD_W-1:0] eff_key;
  logic [POS_W-1:0]  eff_pos;
  logic [7:0]        key_byte;

  assign cfg_ready_o = 1'b1;

  // Config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= MULT_RST;
      incr_q <= INCR_RST;
      mod_q  <= MOD_RST;
      seed_q <= SEED_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MULTIPLIER: mult_q <= cfg_data_i;
        REG_INCREMENT:  incr_q <= cfg_data_i;
        REG_MODULUS:    mod_q  <= cfg_data_i;
        REG_SEED:       seed_q <= cfg_data_i[SEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Restart from seed on first, pick the key byte
  assign eff_key  = in_data_i.first ? {{(WORD_W-SEED_W){1'b0}}, seed_q} : key_q;
  assign eff_pos  = in_data_i.first ? '0 : pos_q;
  assign key_byte = eff_key[8*eff_pos +: 8];

  assign sts_o.wrap     = (eff_pos == POS_W'(WORD_BYTES - 1));
  assign sts_o.mod_zero = (mod_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Product, then sum with increment as dividend
  assign prod_d = PROD_W'(mult_q) * PROD_W'(key_q);

  // One restoring shift-subtract step
  assign rem_sh  = {rem_q, dvd_q[PROD_W-1]};
  assign rem_sub = rem_sh - {1'b0, mod_q};
  assign rem_d   = (rem_sh >= {1'b0, mod_q}) ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
  assign dvd_d   = cmd_i.add ? (prod_q + PROD_W'(incr_q)) : {dvd_q[PROD_W-2:0], 1'b0};

  // Key word and byte position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= {{(WORD_W-SEED_W){1'b0}}, SEED_RST};
      pos_q <= '0;
    end else if (cmd_i.take) begin
      key_q <= eff_key;
      pos_q <= eff_pos + 1'b1;
    end else if (cmd_i.key_ld) begin
      key_q <= sts_o.mod_zero ? dvd_q[WORD_W-1:0] : rem_q;
    end
  end

  // Multiply and reduce registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.add || cmd_i.step) begin
      dvd_q <= dvd_d;
    end
    if (cmd_i.add) begin
      rem_q <= '0;
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      out_q.result_byte <= in_data_i.data_byte ^ key_byte;
      out_q.last_out    <= in_data_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/lcg_keystream_xor_cipher.sv =====
// Top level of the LCG keystream XOR cipher: controller plus datapath.
// A result word is registered and is valid in the cycle after its input word is accepted.
// Throughput: one byte per cycle for the first three bytes of a key word while the result
// register has room; after the fourth byte the input stalls for the next-key computation
// (multiply, add, 64 one-bit modulo steps, key load; no modulo steps with a zero modulus).
// Reset: asynchronous, active low; registers take their defaults, key = seed 1.
module lcg_keystream_xor_cipher import lkxc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lkxc_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lkxc_out_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  lkxc_cmd_t cmd;
  lkxc_sts_t sts;

  // Sequencer
  lkxc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Key and byte datapath
  lkxc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // An accepted word shows up in the result register next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted word did not reach result register");

  // At most one datapath command per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.take, cmd.mul, cmd.add, cmd.step, cmd.key_ld}))
    else $error("overlapping datapath commands");

  // Using the last key byte starts the next-key computation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take && sts.wrap |=> cmd.mul && !in_ready_o)
    else $error("next key computation not started after word wrap");

  // Key load ends the computation and is preceded by reduction or add
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.key_ld |-> $past(cmd.step) || $past(cmd.add))
    else $error("key loaded without reduction");

endmodule

// ===== verif/tb_lcg_keystream_xor_cipher.sv =====
// Testbench for the LCG keystream XOR cipher: random traffic against a local keystream model.
module tb_lcg_keystream_xor_cipher;
  import lkxc_pkg::*;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  lkxc_in_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  lkxc_out_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i  = '0;

  // Message bytes waiting to be sent and cipher bytes waiting to come out
  lkxc_in_t  msg_bytes_q[$];
  lkxc_out_t cipher_bytes_q[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count      = 0;

  // Local copy of the generator registers and keystream state
  logic [WORD_W-1:0] lcg_mult = MULT_RST;
  logic [WORD_W-1:0] lcg_incr = INCR_RST;
  logic [WORD_W-1:0] lcg_mod  = MOD_RST;
  logic [SEED_W-1:0] lcg_seed = SEED_RST;
  logic [WORD_W-1:0] key_word = WORD_W'(SEED_RST);
  logic [POS_W-1:0]  key_pos  = '0;

  lcg_keystream_xor_cipher u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Next keystream word; a zero modulus means plain 32-bit wraparound
  function automatic logic [WORD_W-1:0] lcg_next(input logic [WORD_W-1:0] w);
    logic [PROD_W-1:0] t;
    t = PROD_W'(lcg_mult) * PROD_W'(w) + PROD_W'(lcg_incr);
    if (lcg_mod == '0) return t[WORD_W-1:0];
    return WORD_W'(t % PROD_W'(lcg_mod));
  endfunction

  // XOR one byte with the current key byte, then advance the keystream
  function automatic lkxc_out_t keystream_apply(input lkxc_in_t w);
    lkxc_out_t r;
    if (w.first) begin
      key_word = WORD_W'(lcg_seed);
      key_pos  = '0;
    end
    r.result_byte = w.data_byte ^ key_word[8*key_pos +: 8];
    r.last_out    = w.last;
    key_pos = key_pos + 1'b1;
    if (key_pos == '0) key_word = lcg_next(key_word);
    return r;
  endfunction

  // Append one message byte to the send queue
  task automatic put_msg(input lkxc_in_t w);
    msg_bytes_q.insert(msg_bytes_q.size(), w);
  endtask

  // Driver: hold the word until accepted, predict on acceptance, idle at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        cipher_bytes_q.insert(cipher_bytes_q.size(), keystream_apply(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (msg_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i  <= msg_bytes_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted word with the oldest prediction, stall at random
  always @(posedge clk_i) begin
    lkxc_out_t exp_w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (cipher_bytes_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result word %h", out_data_o);
        end else begin
          exp_w = cipher_bytes_q.pop_front();
          if (out_data_o.result_byte !== exp_w.result_byte ||
              out_data_o.last_out !== exp_w.last_out) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: result_byte exp %h got %h, last_out exp %b got %b",
                       exp_w.result_byte, out_data_o.result_byte,
                       exp_w.last_out, out_data_o.last_out);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Write one register and track it; the caller drops valid after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MULTIPLIER: lcg_mult = val;
      REG_INCREMENT:  lcg_incr = val;
      REG_MODULUS:    lcg_mod  = val;
      REG_SEED:       lcg_seed = val[SEED_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_lcg(input logic [31:0] m, input logic [31:0] c,
                             input logic [31:0] md, input logic [31:0] s);
    write_reg(REG_MULTIPLIER, m);
    write_reg(REG_INCREMENT, c);
    write_reg(REG_MODULUS, md);
    write_reg(REG_SEED, s);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for all words out, then let the modulo unit finish its current key word
  task automatic drain;
    while (msg_bytes_q.size() != 0 || cipher_bytes_q.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Queue one message; a tidy one flags first and last on its ends, else flags are random
  task automatic queue_message(input int len, input bit tidy);
    lkxc_in_t w;
    for (int i = 0; i < len; i++) begin
      w.data_byte = 8'($urandom_range(255));
      w.first     = tidy ? (i == 0) : 1'($urandom_range(1));
      w.last      = tidy ? (i == len - 1) : 1'($urandom_range(1));
      put_msg(w);
    end
  endtask

  function automatic lkxc_in_t mk(input logic [7:0] d, input logic f, input logic l);
    lkxc_in_t w;
    w.data_byte = d;
    w.first     = f;
    w.last      = l;
    return w;
  endfunction

  initial begin
    int sent;
    int len;
    logic [31:0] m, c, md, s;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: keystream from the reset seed with no first flag
    put_msg(mk(8'h00, 1'b0, 1'b0));
    put_msg(mk(8'hff, 1'b0, 1'b0));
    put_msg(mk(8'h00, 1'b0, 1'b0));
    put_msg(mk(8'h00, 1'b0, 1'b1));
    put_msg(mk(8'hff, 1'b0, 1'b0));
    put_msg(mk(8'ha5, 1'b0, 1'b0));
    put_msg(mk(8'h5a, 1'b0, 1'b0));
    drain();

    // Seed write must not touch the running key until a first flag
    write_reg(REG_SEED, 32'hffff_ffff);
    cfg_valid_i <= 1'b0;
    put_msg(mk(8'h00, 1'b0, 1'b0));
    put_msg(mk(8'h00, 1'b0, 1'b0));
    // Restart mid-word, run across a word boundary, then continue without first
    put_msg(mk(8'h00, 1'b1, 1'b0));
    put_msg(mk(8'hff, 1'b0, 1'b0));
    put_msg(mk(8'h00, 1'b0, 1'b0));
    put_msg(mk(8'hff, 1'b0, 1'b0));
    put_msg(mk(8'h00, 1'b0, 1'b0));
    put_msg(mk(8'h00, 1'b0, 1'b1));
    put_msg(mk(8'h00, 1'b0, 1'b0));
    put_msg(mk(8'hff, 1'b0, 1'b1));
    put_msg(mk(8'h00, 1'b1, 1'b1));
    drain();

    // Random phases: new generator settings and idle pattern in each
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      m  = $urandom();
      c  = $urandom();
      md = $urandom();
      s  = $urandom();
      case (p)
        0: begin m = 32'hffff_ffff; c = 32'hffff_ffff; md = 32'h0; s = 32'h7fff_ffff; end
        1: begin m = 32'h0; c = 32'h0; md = 32'h1; s = 32'h0; end
        2: md = 32'h8000_0000;
        3: begin m = MULT_RST; c = INCR_RST; md = 32'hffff_ffff; end
        5: begin c = 32'h0; md = 32'($urandom_range(1, 1000)); end
        6: md = 32'h8000_0001;
        default: ;
      endcase
      if (md == '0 && p > 1) md = 32'h1;
      program_lcg(m, c, md, s);
      @(posedge clk_i);

      sent = 0;
      while (sent < 200) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        queue_message(len, $urandom_range(99) < 85);
        sent += len;
      end
      drain();
    end

    if (err_count == 0) $display("PASS lcg_keystream_xor_cipher");
    else $display("FAIL lcg_keystream_xor_cipher");
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("FAIL lcg_keystream_xor_cipher");
    $finish;
  end

endmodule
